[hw/rtl/tkfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkfr_pkg
// Shared widths, defaults and control types of the top-k frequency ranker.
// ----------------------------------------------------------------------------
package tkfr_pkg;

	localparam int ID_W   = 16;
	localparam int RANK_W = 4;
	localparam int TOPC_W = 5;

	localparam logic [TOPC_W-1:0] TOPC_RESET = 5'd3;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int MAX_TOP_DEF     = 16;
	localparam int COUNT_BITS_DEF  = 16;

	// sequencer to chain
	typedef struct packed {
		logic match_en;   // look up the query, latch old and new count
		logic apply_en;   // reorder the chain in one step
	} tkfr_ctl_t;

	// chain to sequencer
	typedef struct packed {
		logic hit;        // query id already held
		logic sat;        // its count sits at the maximum
	} tkfr_stat_t;

endpackage
`default_nettype wire

[hw/rtl/tkfr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkfr_if
// Valid/ready channels of the ranker: query words in, listing words out.
// ----------------------------------------------------------------------------
interface tkfr_query_if;
	logic                      valid;
	logic                      ready;
	logic [tkfr_pkg::ID_W-1:0] query_id;

	modport source (output valid, output query_id, input ready);
	modport sink   (input valid, input query_id, output ready);
endinterface

interface tkfr_result_if;
	logic                        valid;
	logic                        ready;
	logic [tkfr_pkg::ID_W-1:0]   asked_id;
	logic [tkfr_pkg::RANK_W-1:0] rank;
	logic [tkfr_pkg::ID_W-1:0]   ranked_id;
	logic                        last;

	modport source (output valid, output asked_id, output rank, output ranked_id,
		output last, input ready);
	modport sink   (input valid, input asked_id, input rank, input ranked_id,
		input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/tkfr_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkfr_cell
// One rank slot: holds an id and its count, compares itself with the
// query, and on a reorder keeps, takes its upper neighbour or the new entry.
// ----------------------------------------------------------------------------
module tkfr_cell #(
	parameter int COUNT_BITS = tkfr_pkg::COUNT_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      apply,
	input  wire logic                      hit,
	input  wire logic [tkfr_pkg::ID_W-1:0] q,
	input  wire logic [COUNT_BITS-1:0]     old_cnt,
	input  wire logic [COUNT_BITS-1:0]     new_cnt,
	input  wire logic                      up_valid,
	input  wire logic [tkfr_pkg::ID_W-1:0] up_id,
	input  wire logic [COUNT_BITS-1:0]     up_cnt,
	input  wire logic                      up_o,
	output logic                           valid,
	output logic [tkfr_pkg::ID_W-1:0]      id,
	output logic [COUNT_BITS-1:0]          cnt,
	output logic                           match,
	output logic                           o
);

	logic                      valid_q;
	logic [tkfr_pkg::ID_W-1:0] id_q;
	logic [COUNT_BITS-1:0]     cnt_q;
	logic                      le;
	logic                      take_up;
	logic                      take_new;

	function automatic logic outranks(
		input logic [COUNT_BITS-1:0]     ca,
		input logic [tkfr_pkg::ID_W-1:0] ia,
		input logic [COUNT_BITS-1:0]     cb,
		input logic [tkfr_pkg::ID_W-1:0] ib
	);
		if (ca != cb)
			return ca > cb;
		return ia < ib;
	endfunction

	assign match = valid_q && (id_q == q);
	// empty slot loses to anything
	assign o     = !valid_q || outranks(new_cnt, q, cnt_q, id_q);
	// on a hit only slots at or above the old position move
	assign le    = !hit || (valid_q && !outranks(old_cnt, q, cnt_q, id_q));

	assign take_up  = apply && le && up_o;
	assign take_new = apply && le && !up_o && o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_up) begin
			valid_q <= up_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_up) begin
			id_q  <= up_id;
			cnt_q <= up_cnt;
		end else if (take_new) begin
			id_q  <= q;
			cnt_q <= new_cnt;
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign cnt   = cnt_q;

endmodule
`default_nettype wire

[hw/rtl/tkfr_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkfr_chain
// Sorted row of rank cells. Lookup stage latches hit and counts, the
// reorder stage shifts all affected slots down by one together.
// ----------------------------------------------------------------------------
module tkfr_chain #(
	parameter int TABLE_DEPTH = tkfr_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_TOP     = tkfr_pkg::MAX_TOP_DEF,
	parameter int COUNT_BITS  = tkfr_pkg::COUNT_BITS_DEF,
	localparam int LIST_W     = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tkfr_pkg::tkfr_ctl_t       ctl,
	input  wire logic [tkfr_pkg::ID_W-1:0] q,
	input  wire logic [LIST_W-1:0]         list_idx,
	output tkfr_pkg::tkfr_stat_t           stat,
	output logic [tkfr_pkg::ID_W-1:0]      list_id
);

	logic                      valid_w [TABLE_DEPTH];
	logic [tkfr_pkg::ID_W-1:0] id_w    [TABLE_DEPTH];
	logic [COUNT_BITS-1:0]     cnt_w   [TABLE_DEPTH];
	logic                      match_w [TABLE_DEPTH];
	logic                      o_w     [TABLE_DEPTH];
	logic [tkfr_pkg::ID_W-1:0] list_ids [MAX_TOP];

	logic                  hit_c;
	logic [COUNT_BITS-1:0] old_c;
	logic                  hit_s1;
	logic                  sat_s1;
	logic [COUNT_BITS-1:0] old_cnt_s1;
	logic [COUNT_BITS-1:0] new_cnt_s1;
	logic                  apply;

	// ids are distinct, so at most one slot matches
	always_comb begin
		hit_c = 1'b0;
		old_c = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_c = hit_c | match_w[i];
			old_c = old_c | (match_w[i] ? cnt_w[i] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
			sat_s1 <= 1'b0;
		end else if (ctl.match_en) begin
			hit_s1 <= hit_c;
			sat_s1 <= hit_c && (old_c == '1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.match_en) begin
			old_cnt_s1 <= old_c;
			new_cnt_s1 <= hit_c ? old_c + 1'b1 : COUNT_BITS'(1);
		end
	end

	// saturated count keeps its place
	assign apply = ctl.apply_en && !(hit_s1 && sat_s1);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
		logic                      up_valid;
		logic [tkfr_pkg::ID_W-1:0] up_id;
		logic [COUNT_BITS-1:0]     up_cnt;
		logic                      up_o;

		if (i == 0) begin : g_head
			assign up_valid = 1'b0;
			assign up_id    = '0;
			assign up_cnt   = '0;
			assign up_o     = 1'b0;
		end else begin : g_body
			assign up_valid = valid_w[i-1];
			assign up_id    = id_w[i-1];
			assign up_cnt   = cnt_w[i-1];
			assign up_o     = o_w[i-1];
		end

		tkfr_cell #(
			.COUNT_BITS (COUNT_BITS)
		) u_slot (
			.clk      (clk),
			.arst_n   (arst_n),
			.apply    (apply),
			.hit      (hit_s1),
			.q        (q),
			.old_cnt  (old_cnt_s1),
			.new_cnt  (new_cnt_s1),
			.up_valid (up_valid),
			.up_id    (up_id),
			.up_cnt   (up_cnt),
			.up_o     (up_o),
			.valid    (valid_w[i]),
			.id       (id_w[i]),
			.cnt      (cnt_w[i]),
			.match    (match_w[i]),
			.o        (o_w[i])
		);
	end

	for (genvar j = 0; j < MAX_TOP; j++) begin : g_list
		if (j < TABLE_DEPTH) begin : g_tap
			assign list_ids[j] = id_w[j];
		end else begin : g_none
			assign list_ids[j] = '0;
		end
	end

	assign list_id  = list_ids[list_idx];
	assign stat.hit = hit_s1;
	assign stat.sat = sat_s1;

endmodule
`default_nettype wire

[hw/rtl/top_k_frequency_ranker_top.sv]
// An accepted query enters S_LIST (skipped if n = 0), which loads each listing
// word into the output word register. Queries are taken only in S_IDLE, so a
// new one waits for the last: n = min(top_count, MAX_TOP, entries held) words
// stream, then lookup (S_MATCH) and reorder (S_APPLY); a stall holds S_LIST.
// Reset: table empty, top_count = 3; no clearing pass, ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_frequency_ranker_top
// Ranked id/count table: lists the top ids per query, then counts the query.
// ----------------------------------------------------------------------------
module top_k_frequency_ranker_top #(
	parameter int TABLE_DEPTH = tkfr_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_TOP     = tkfr_pkg::MAX_TOP_DEF,
	parameter int COUNT_BITS  = tkfr_pkg::COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [tkfr_pkg::TOPC_W-1:0] cfg_wr_data,
	tkfr_query_if.sink                       query,
	tkfr_result_if.source                    result
);

	localparam int LIST_W = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
	localparam int N_W    = $clog2(MAX_TOP + 1);
	localparam int USED_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LIST  = 4'b0010,
		S_MATCH = 4'b0100,
		S_APPLY = 4'b1000
	} tkfr_state_t;

	tkfr_state_t               state_q;
	logic [tkfr_pkg::TOPC_W-1:0] top_count_q;
	logic [USED_W-1:0]         used_q;
	logic [tkfr_pkg::ID_W-1:0] q_q;
	logic [N_W-1:0]            n_q;
	logic [LIST_W-1:0]         idx_q;

	logic                        out_valid_q;
	logic [tkfr_pkg::ID_W-1:0]   out_asked_q;
	logic [tkfr_pkg::RANK_W-1:0] out_rank_q;
	logic [tkfr_pkg::ID_W-1:0]   out_ranked_q;
	logic                        out_last_q;

	tkfr_pkg::tkfr_ctl_t  ctl;
	tkfr_pkg::tkfr_stat_t stat;
	logic [tkfr_pkg::ID_W-1:0] list_id;

	logic        accept;
	logic        load;
	logic        at_last;
	logic        full;
	logic [31:0] tc_sat;
	logic [31:0] used_ext;
	logic [31:0] n_calc;
	logic [31:0] idx_ext;

	assign accept = query.valid && query.ready;
	assign load   = (state_q == S_LIST) && (!out_valid_q || result.ready);
	assign full   = (used_q == USED_W'(TABLE_DEPTH));

	always_comb begin
		tc_sat   = (32'(top_count_q) > 32'(MAX_TOP)) ? 32'(MAX_TOP) : 32'(top_count_q);
		used_ext = 32'(used_q);
		n_calc   = (tc_sat < used_ext) ? tc_sat : used_ext;
		idx_ext  = 32'(idx_q);
	end

	assign at_last = (idx_ext + 32'd1 == 32'(n_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= tkfr_pkg::TOPC_RESET;
		end else if (cfg_wr_en) begin
			top_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= n_calc[N_W-1:0];
						idx_q   <= '0;
						state_q <= (n_calc == 32'd0) ? S_MATCH : S_LIST;
					end
				end
				S_LIST: begin
					if (load) begin
						idx_q <= idx_q + LIST_W'(1);
						if (at_last)
							state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			q_q <= query.query_id;
	end

	// entry count: a miss that finds room adds one; eviction keeps it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if ((state_q == S_APPLY) && !stat.hit && !full) begin
			used_q <= used_q + USED_W'(1);
		end
	end

	assign ctl.match_en = (state_q == S_MATCH);
	assign ctl.apply_en = (state_q == S_APPLY);

	tkfr_chain #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_TOP     (MAX_TOP),
		.COUNT_BITS  (COUNT_BITS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.q        (q_q),
		.list_idx (idx_q),
		.stat     (stat),
		.list_id  (list_id)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_asked_q  <= q_q;
			out_rank_q   <= idx_ext[tkfr_pkg::RANK_W-1:0];
			out_ranked_q <= list_id;
			out_last_q   <= at_last;
		end
	end

	assign query.ready      = (state_q == S_IDLE);
	assign result.valid     = out_valid_q;
	assign result.asked_id  = out_asked_q;
	assign result.rank      = out_rank_q;
	assign result.ranked_id = out_ranked_q;
	assign result.last      = out_last_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_used_grow: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_APPLY) && !stat.hit && !full) |=> (used_q == $past(used_q) + USED_W'(1)))
		else $error("miss with room did not add an entry");

	a_hit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_APPLY) && stat.hit) |-> (used_q != '0))
		else $error("hit reported on an empty table");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (32'(n_q) <= used_ext))
		else $error("listing beyond held entries");

endmodule
`default_nettype wire
